@@ hw/rtl/bm3_pkg.sv @@
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared types and constants for the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
package bm3_pkg;

    localparam int PIX_W     = 8;
    localparam int OP_W      = 2;
    localparam int WID_W     = 11;
    localparam int HGT_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [PIX_W-1:0] PIX_SET = 8'hFF;

    localparam logic [OP_W-1:0] OP_GROW        = 2'd0;
    localparam logic [OP_W-1:0] OP_SHRINK      = 2'd1;
    localparam logic [OP_W-1:0] OP_GROW_SHRINK = 2'd2;
    localparam logic [OP_W-1:0] OP_SHRINK_GROW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [WID_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd1024;
    localparam logic [WID_W-1:0] WIDTH_MIN  = 11'd3;
    localparam logic [HGT_W-1:0] HEIGHT_MIN = 13'd3;

    // output queue
    localparam int Q_DEPTH = 16;
    localparam int Q_AW    = 4;
    localparam int Q_CNT_W = 5;

    // one line buffer entry: two previous rows and the real-pixel mark
    typedef struct packed {
        logic [PIX_W-1:0] row0;
        logic [PIX_W-1:0] row1;
        logic             vld;
    } t_line;

    // per-item token leaving a stage
    typedef struct packed {
        logic             vld;
        logic             got;
        logic             flush;
        logic             fend;
        logic [PIX_W-1:0] px;
    } t_tok;

    typedef struct packed {
        logic             fend;
        logic [PIX_W-1:0] px;
    } t_res;

endpackage

@@ hw/rtl/bm3_stage.sv @@
// ----------------------------------------------------------------------------
// bm3_stage
// One 3x3 morphology stage: line buffer memory, window and result register.
// ----------------------------------------------------------------------------
module bm3_stage
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic [AW-1:0]    i_clr_addr,
    input  logic             i_grow,
    input  logic [WID_W-1:0] i_w,
    input  logic [HGT_W-1:0] i_h,
    input  logic             i_tok,
    input  logic             i_push,
    input  logic             i_real,
    input  logic [PIX_W-1:0] i_px,
    input  logic             i_flush,
    output t_tok             o_res
);

    t_line            mem [MAX_WIDTH];
    t_line            r_rd;
    t_line            wr_line;

    logic [AW-1:0]    r_ptr;
    logic [AW-1:0]    p;
    logic [AW-1:0]    p_next;
    logic [WID_W-1:0] r_col;
    logic [HGT_W-1:0] r_row;
    logic [WID_W:0]   col_inc;
    logic [HGT_W:0]   row_inc;
    logic             act;

    logic             r_a_tok;
    logic             r_a_act;
    logic             r_a_real;
    logic [PIX_W-1:0] r_a_px;
    logic [AW-1:0]    r_a_p;
    logic             r_a_flush;

    logic [PIX_W-1:0] r_win [3][3];
    logic [2:0]       r_mv;
    logic             r_b_tok;
    logic             r_b_fire;
    logic             r_b_flush;

    logic [WID_W-1:0] r_ocol;
    logic [HGT_W-1:0] r_orow;
    logic [WID_W-1:0] w_m1;
    logic [HGT_W-1:0] h_m1;
    logic             col_last;
    logic             row_last;
    logic             inner;
    logic             any_nz;
    logic             any_z;
    logic [PIX_W-1:0] res_px;
    t_tok             r_o;

    // input side: pointer and position
    always_comb begin
        p       = (32'(r_ptr) >= 32'(i_w)) ? '0 : r_ptr;
        p_next  = (32'(p) + 32'd1 >= 32'(i_w)) ? '0 : p + AW'(1);
        act     = i_tok && i_push && (i_real || (r_col == '0 && r_row == '0));
        col_inc = {1'b0, r_col} + 1'b1;
        row_inc = {1'b0, r_row} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (act) begin
            r_ptr <= p_next;
            if (i_real) begin
                if (col_inc >= {1'b0, i_w}) begin
                    r_col <= '0;
                    r_row <= (row_inc >= {1'b0, i_h}) ? '0 : row_inc[HGT_W-1:0];
                end else begin
                    r_col <= col_inc[WID_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tok <= 1'b0;
            r_a_act <= 1'b0;
        end else begin
            r_a_tok <= i_tok;
            r_a_act <= act;
        end
    end

    // a flush shifts in a zero
    always_ff @(posedge i_clk) begin
        r_a_real  <= i_real;
        r_a_px    <= i_real ? i_px : '0;
        r_a_p     <= p;
        r_a_flush <= i_flush;
    end

    // line buffer
    always_comb begin
        wr_line.row0 = r_a_px;
        wr_line.row1 = r_rd.row0;
        wr_line.vld  = r_a_real;
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            mem[i_clr_addr] <= '0;
        end else if (r_a_act) begin
            mem[r_a_p] <= wr_line;
        end
        if (act) begin
            r_rd <= mem[p];
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (r_a_act) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_rd.row1;
            r_win[1][2] <= r_rd.row0;
            r_win[2][2] <= r_a_px;
        end
        r_b_flush <= r_a_flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv     <= '0;
            r_b_tok  <= 1'b0;
            r_b_fire <= 1'b0;
        end else begin
            r_b_tok  <= r_a_tok;
            r_b_fire <= r_a_act && r_mv[2];
            if (r_a_act) begin
                r_mv <= {r_rd.vld, r_mv[2:1]};
            end
        end
    end

    // window evaluation
    always_comb begin
        w_m1     = i_w - 1'b1;
        h_m1     = i_h - 1'b1;
        col_last = r_ocol >= w_m1;
        row_last = r_orow >= h_m1;
        inner    = (r_ocol != '0) && (r_ocol < w_m1) && (r_orow != '0) && (r_orow < h_m1);
        any_nz   = 1'b0;
        any_z    = 1'b0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_win[r][c] != '0) any_nz = 1'b1;
                if (r_win[r][c] == '0) any_z = 1'b1;
            end
        end
        res_px = r_win[1][1];
        if (inner) begin
            if (i_grow && any_nz) res_px = PIX_SET;
            if (!i_grow && any_z) res_px = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocol    <= '0;
            r_orow    <= '0;
            r_o.vld   <= 1'b0;
            r_o.got   <= 1'b0;
        end else begin
            r_o.vld <= r_b_tok;
            r_o.got <= r_b_tok && r_b_fire;
            if (r_b_tok && r_b_fire) begin
                if (col_last) begin
                    r_ocol <= '0;
                    r_orow <= row_last ? '0 : r_orow + 1'b1;
                end else begin
                    r_ocol <= r_ocol + 1'b1;
                end
            end
        end
        r_o.flush <= r_b_flush;
        r_o.fend  <= col_last && row_last;
        r_o.px    <= res_px;
    end

    assign o_res = r_o;

`ifndef NO_ASSERTIONS
    a_fire_has_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_fire |-> r_b_tok)
        else $error("stage fires without an item in flight");
`endif

endmodule

@@ hw/rtl/bm3_fifo.sv @@
// ----------------------------------------------------------------------------
// bm3_fifo
// Output queue that decouples the result stream from the window pipeline.
// ----------------------------------------------------------------------------
module bm3_fifo
    import bm3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_data,
    input  logic i_pop,
    output logic o_valid,
    output t_res o_data
);

    t_res               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wptr;
    logic [Q_AW-1:0]    r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            r_cnt <= r_cnt + {{(Q_CNT_W-1){1'b0}}, i_push} - {{(Q_CNT_W-1){1'b0}}, i_pop};
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rptr];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != Q_CNT_W'(Q_DEPTH)) || i_pop)
        else $error("output queue overflow");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ hw/rtl/binary_morphology_3x3.sv @@
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// 3x3 binary grow/shrink on a raster pixel stream, one or two chained stages.
// ----------------------------------------------------------------------------
// usage
//   slave channel: one pixel per transaction, tuser high marks a flush item
//   that carries no pixel and only pushes delayed pixels out after a frame
//   master channel: one result pixel per transaction, tlast on the last
//   pixel of a frame
//   config port: write operation, width and height while the block is idle
//   throughput: one transaction per cycle while tready is high
//   path: each stage holds one row plus one pixel; beyond that a result
//   passes the input, window and result registers of each active stage in
//   turn, then the output queue, before it appears on the master channel
//   reset: after i_rst_n the line buffers are cleared, one entry per cycle,
//   until all MAX_WIDTH entries are zero; tready stays low during that pass
//   stall: a 16-entry output queue absorbs results; tready drops once 16
//   transactions are in flight or queued, so nothing is lost
// ----------------------------------------------------------------------------
module binary_morphology_3x3
    import bm3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,  // [7:0] pixel_in
    input  logic                 i_s_axis_tuser,  // [0] flush
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [7:0]           o_m_axis_tdata,  // [7:0] pixel_out
    output logic                 o_m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [OP_W-1:0]    r_op;
    logic [WID_W-1:0]   r_width;
    logic [HGT_W-1:0]   r_height;
    logic [WID_W-1:0]   w_eff;
    logic [HGT_W-1:0]   h_eff;
    logic               two;
    logic               grow1;

    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    logic               in_acc;
    t_tok               s1;
    t_tok               s2;
    logic               s2_tok;

    logic               q_push;
    t_res               q_in;
    logic               q_valid;
    t_res               q_out;
    logic               pop;
    logic               drop;

    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_GROW;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_OPERATION: r_op     <= i_cfg_data[OP_W-1:0];
                REG_WIDTH:     r_width  <= i_cfg_data[WID_W-1:0];
                REG_HEIGHT:    r_height <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff = r_width;
        if (r_width < WIDTH_MIN) w_eff = WIDTH_MIN;
        if (32'(r_width) > MAX_WIDTH) w_eff = WID_W'(MAX_WIDTH);
        h_eff = (r_height < HEIGHT_MIN) ? HEIGHT_MIN : r_height;
    end

    always_comb begin
        unique case (r_op)
            OP_GROW:        begin two = 1'b0; grow1 = 1'b1; end
            OP_SHRINK:      begin two = 1'b0; grow1 = 1'b0; end
            OP_GROW_SHRINK: begin two = 1'b1; grow1 = 1'b1; end
            OP_SHRINK_GROW: begin two = 1'b1; grow1 = 1'b0; end
            default:        begin two = 1'b0; grow1 = 1'b1; end
        endcase
    end

    // line buffer clearing after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (32'(r_clr_addr) == MAX_WIDTH - 1) r_clr_busy <= 1'b0;
        end
    end

    assign o_s_axis_tready = !r_clr_busy && (r_cnt < Q_CNT_W'(Q_DEPTH));
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    bm3_stage #(.MAX_WIDTH(MAX_WIDTH)) u_stage1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (r_clr_busy),
        .i_clr_addr (r_clr_addr),
        .i_grow     (grow1),
        .i_w        (w_eff),
        .i_h        (h_eff),
        .i_tok      (in_acc),
        .i_push     (1'b1),
        .i_real     (!i_s_axis_tuser),
        .i_px       (i_s_axis_tdata),
        .i_flush    (i_s_axis_tuser),
        .o_res      (s1)
    );

    assign s2_tok = s1.vld && two;

    bm3_stage #(.MAX_WIDTH(MAX_WIDTH)) u_stage2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (r_clr_busy),
        .i_clr_addr (r_clr_addr),
        .i_grow     (!grow1),
        .i_w        (w_eff),
        .i_h        (h_eff),
        .i_tok      (s2_tok),
        .i_push     (s1.got || s1.flush),
        .i_real     (s1.got),
        .i_px       (s1.px),
        .i_flush    (s1.flush),
        .o_res      (s2)
    );

    // result selection
    always_comb begin
        q_push  = 1'b0;
        drop    = 1'b0;
        q_in.px   = s1.px;
        q_in.fend = s1.fend;
        if (s1.vld && !two) begin
            q_push = s1.got;
            drop   = !s1.got;
        end
        if (s2.vld) begin
            q_push    = s2.got;
            drop      = !s2.got;
            q_in.px   = s2.px;
            q_in.fend = s2.fend;
        end
    end

    bm3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    assign pop             = q_valid && i_m_axis_tready;
    assign o_m_axis_tvalid = q_valid;
    assign o_m_axis_tdata  = q_out.px;
    assign o_m_axis_tlast  = q_out.fend;

    // transactions in flight or queued
    assign n_cnt = r_cnt + {{(Q_CNT_W-1){1'b0}}, in_acc}
                 - {{(Q_CNT_W-1){1'b0}}, pop} - {{(Q_CNT_W-1){1'b0}}, drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("outstanding count exceeds queue depth");
    a_pipe_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1.vld || o_m_axis_tvalid) |-> (r_cnt != '0))
        else $error("item in flight without outstanding count");
`endif

endmodule
